@@ rtl/vwc_pkg.sv @@
// types and constants shared by the vertex window cut block
`default_nettype none
package vwc_pkg;
   typedef enum logic [1:0] {
      KIND_LOAD_E = 2'd0,
      KIND_LOAD_L = 2'd1,
      KIND_EVAL   = 2'd2,
      KIND_EVAL3  = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ST_EVALUATED = 2'd0,
      ST_STORED    = 2'd1,
      ST_DROPPED   = 2'd2
   } status_type;

   localparam logic [1:0] REG_VZ_MIN = 2'd0;
   localparam logic [1:0] REG_VZ_MAX = 2'd1;
   localparam logic [1:0] REG_FIXED  = 2'd2;
   localparam logic [1:0] REG_HALF   = 2'd3;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SRCH_RD,
      S_SRCH_CHK,
      S_LO_RD,
      S_LO_WAIT,
      S_MUL_DS,
      S_MUL_LO0,
      S_MUL_LO1,
      S_MUL_HI0,
      S_MUL_HI1,
      S_CMP,
      S_DONE
   } state_type;
endpackage
`default_nettype wire

@@ rtl/vertex_window_cut.sv @@
// top level of the vertex window cut: knot tables, search sequencer, shared multiplier
// load: busy in the DONE state after the start beat, result strobe in the cycle after that
// evaluate: a read and a compare step per knot visited in each table, then the lower knot read
//   and the bracket products when the angle lies between two knots, then a compare step per table
// fixed mode: busy in SRCH_RD and DONE; start is taken again in the strobe cycle, receiver never stalls
// reset returns config registers to their defaults, empties both tables, idles the sequencer
`default_nettype none
module vertex_window_cut #(
   parameter int KNOTS = 64
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         start,
   output logic        busy,
   input  wire  [1:0]  req_kind,
   input  wire  [15:0] req_knot_angle,
   input  wire  signed [15:0] req_knot_low,
   input  wire  signed [15:0] req_knot_high,
   input  wire  signed [15:0] req_electron_vertex,
   input  wire  signed [15:0] req_lead_vertex,
   input  wire  [15:0] req_electron_angle,
   input  wire  [15:0] req_lead_angle,
   output logic        rsp_valid,
   output logic [1:0]  rsp_status,
   output logic        rsp_accepted,
   output logic        rsp_target_ok,
   output logic        rsp_electron_window_ok,
   output logic        rsp_lead_window_ok,
   input  wire         csr_we,
   input  wire  [1:0]  csr_index,
   input  wire  [15:0] csr_wdata
);
   localparam int AW = (KNOTS > 1) ? $clog2(KNOTS) : 1;
   localparam int CW = $clog2(KNOTS + 1);
   localparam logic [CW-1:0] FULL = CW'(KNOTS);

   // window modes
   localparam logic [1:0] MODE_INTERP = 2'd0;
   localparam logic [1:0] MODE_CLAMP  = 2'd1;
   localparam logic [1:0] MODE_EMPTY  = 2'd2;

   // config registers
   logic signed [15:0] vz_min_ff, vz_max_ff;
   logic               fixed_ff;
   logic [14:0]        half_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vz_min_ff <= -16'sd2458;
         vz_max_ff <= 16'sd1536;
         fixed_ff  <= 1'b0;
         half_ff   <= 15'd1024;
      end else if (csr_we) begin
         unique case (csr_index)
            vwc_pkg::REG_VZ_MIN: vz_min_ff <= csr_wdata;
            vwc_pkg::REG_VZ_MAX: vz_max_ff <= csr_wdata;
            vwc_pkg::REG_FIXED:  fixed_ff  <= csr_wdata[0];
            vwc_pkg::REG_HALF:   half_ff   <= csr_wdata[14:0];
            default: ;
         endcase
      end
   end

   // knot memories, one per table, each entry angle/low/high packed
   logic [47:0] e_mem [KNOTS];
   logic [47:0] l_mem [KNOTS];
   logic [CW-1:0] e_cnt_ff, l_cnt_ff;

   vwc_pkg::state_type state_ff, state_in;
   logic          tab_ff, tab_in;        // 0 electron, 1 lead
   logic [CW-1:0] k_ff, k_in;
   logic [47:0]   rd_ff;
   logic [47:0]   up_ff, up_in;          // upper knot
   logic [1:0]    mode_ff, mode_in;      // interp, clamp to rd knot, or empty
   logic signed [16:0] d_ff;
   logic signed [15:0] ev_ff;
   logic [15:0]   ea_ff, la_ff;
   logic          e_ok_ff, e_ok_in;
   logic          kind_load_ff;
   logic [1:0]    stat_ff;

   // shared multiplier
   logic signed [17:0] ma;
   logic signed [16:0] mb;
   logic signed [34:0] prod;
   logic signed [35:0] acc_ff, acc_in;   // lo sum then hi sum
   logic signed [35:0] ds_ff, ds_in;
   logic signed [35:0] lsum_ff, lsum_in;
   assign prod = ma * mb;

   logic [15:0] theta;
   assign theta = tab_ff ? la_ff : ea_ff;
   logic [CW-1:0] cnt_sel;
   assign cnt_sel = tab_ff ? l_cnt_ff : e_cnt_ff;

   logic [AW-1:0] rd_addr;
   logic          do_rd;
   logic          ld_go;
   logic [1:0]    kind;
   assign kind  = req_kind;
   assign ld_go = start && !busy
                  && (kind == vwc_pkg::KIND_LOAD_E || kind == vwc_pkg::KIND_LOAD_L);

   always_ff @(posedge clock) begin
      if (ld_go && kind == vwc_pkg::KIND_LOAD_E && e_cnt_ff != FULL)
         e_mem[e_cnt_ff[AW-1:0]] <= {req_knot_angle, req_knot_low, req_knot_high};
      if (ld_go && kind == vwc_pkg::KIND_LOAD_L && l_cnt_ff != FULL)
         l_mem[l_cnt_ff[AW-1:0]] <= {req_knot_angle, req_knot_low, req_knot_high};
      if (do_rd)
         rd_ff <= tab_ff ? l_mem[rd_addr] : e_mem[rd_addr];
   end

   // span and offset of the bracket
   logic [16:0] s_span, w_off;
   assign s_span = {1'b0, up_ff[47:32]} - {1'b0, rd_ff[47:32]};
   assign w_off  = {1'b0, theta} - {1'b0, rd_ff[47:32]};

   // window check from acc/lsum against d*s, or direct for clamp
   logic win_ok;
   always_comb begin
      if (mode_ff == MODE_EMPTY)
         win_ok = 1'b0;
      else if (mode_ff == MODE_CLAMP)
         win_ok = (d_ff >= 17'(signed'(rd_ff[31:16])))
                  && (d_ff <= 17'(signed'(rd_ff[15:0])));
      else
         win_ok = (ds_ff >= lsum_ff) && (ds_ff <= acc_ff);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         vwc_pkg::S_IDLE:
            if (start) state_in = (kind == vwc_pkg::KIND_LOAD_E || kind == vwc_pkg::KIND_LOAD_L)
                                  ? vwc_pkg::S_DONE : vwc_pkg::S_SRCH_RD;
         vwc_pkg::S_SRCH_RD:
            if (fixed_ff) state_in = vwc_pkg::S_DONE;
            else if (cnt_sel == '0) state_in = vwc_pkg::S_CMP;
            else state_in = vwc_pkg::S_SRCH_CHK;
         vwc_pkg::S_SRCH_CHK:
            if (rd_ff[47:32] >= theta)
               state_in = (k_ff == '0) ? vwc_pkg::S_CMP : vwc_pkg::S_LO_RD;
            else if (k_ff + 1'b1 == cnt_sel) state_in = vwc_pkg::S_CMP;
            else state_in = vwc_pkg::S_SRCH_RD;
         vwc_pkg::S_LO_RD:   state_in = vwc_pkg::S_LO_WAIT;
         vwc_pkg::S_LO_WAIT: state_in = vwc_pkg::S_MUL_DS;
         vwc_pkg::S_MUL_DS:  state_in = vwc_pkg::S_MUL_LO0;
         vwc_pkg::S_MUL_LO0: state_in = vwc_pkg::S_MUL_LO1;
         vwc_pkg::S_MUL_LO1: state_in = vwc_pkg::S_MUL_HI0;
         vwc_pkg::S_MUL_HI0: state_in = vwc_pkg::S_MUL_HI1;
         vwc_pkg::S_MUL_HI1: state_in = vwc_pkg::S_CMP;
         vwc_pkg::S_CMP:
            state_in = (tab_ff == 1'b0) ? vwc_pkg::S_SRCH_RD : vwc_pkg::S_DONE;
         vwc_pkg::S_DONE:    state_in = vwc_pkg::S_IDLE;
         default:            state_in = vwc_pkg::S_IDLE;
      endcase
   end

   // datapath controls
   always_comb begin
      tab_in  = tab_ff;
      k_in    = k_ff;
      up_in   = up_ff;
      mode_in = mode_ff;
      e_ok_in = e_ok_ff;
      acc_in  = acc_ff;
      ds_in   = ds_ff;
      lsum_in = lsum_ff;
      do_rd   = 1'b0;
      rd_addr = k_ff[AW-1:0];
      ma      = '0;
      mb      = '0;
      unique case (state_ff)
         vwc_pkg::S_IDLE: begin
            tab_in = 1'b0;
            k_in   = '0;
         end
         vwc_pkg::S_SRCH_RD: begin
            do_rd   = 1'b1;
            mode_in = (cnt_sel == '0) ? MODE_EMPTY : MODE_INTERP;
         end
         vwc_pkg::S_SRCH_CHK: begin
            if (rd_ff[47:32] >= theta) begin
               up_in = rd_ff;
               if (k_ff == '0) mode_in = MODE_CLAMP;
               else k_in = k_ff - 1'b1;
            end else if (k_ff + 1'b1 == cnt_sel) begin
               mode_in = MODE_CLAMP;
            end else begin
               k_in = k_ff + 1'b1;
            end
         end
         vwc_pkg::S_LO_RD: do_rd = 1'b1;
         vwc_pkg::S_MUL_DS: begin
            ma = 18'(d_ff);
            mb = signed'(s_span);
            ds_in = 36'(prod);
         end
         vwc_pkg::S_MUL_LO0: begin
            ma = 18'(signed'(rd_ff[31:16]));
            mb = signed'(s_span - w_off);
            acc_in = 36'(prod);
         end
         vwc_pkg::S_MUL_LO1: begin
            ma = 18'(signed'(up_ff[31:16]));
            mb = signed'(w_off);
            lsum_in = acc_ff + 36'(prod);
         end
         vwc_pkg::S_MUL_HI0: begin
            ma = 18'(signed'(rd_ff[15:0]));
            mb = signed'(s_span - w_off);
            acc_in = 36'(prod);
         end
         vwc_pkg::S_MUL_HI1: begin
            ma = 18'(signed'(up_ff[15:0]));
            mb = signed'(w_off);
            acc_in = acc_ff + 36'(prod);
         end
         vwc_pkg::S_CMP: begin
            if (tab_ff == 1'b0) e_ok_in = win_ok;
            tab_in = 1'b1;
            k_in   = '0;
         end
         default: ;
      endcase
   end

   logic l_ok_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= vwc_pkg::S_IDLE;
         e_cnt_ff     <= '0;
         l_cnt_ff     <= '0;
         rsp_valid    <= 1'b0;
      end else begin
         state_ff  <= state_in;
         rsp_valid <= (state_ff == vwc_pkg::S_DONE);
         if (ld_go && kind == vwc_pkg::KIND_LOAD_E && e_cnt_ff != FULL)
            e_cnt_ff <= e_cnt_ff + 1'b1;
         if (ld_go && kind == vwc_pkg::KIND_LOAD_L && l_cnt_ff != FULL)
            l_cnt_ff <= l_cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      tab_ff  <= tab_in;
      k_ff    <= k_in;
      up_ff   <= up_in;
      mode_ff <= mode_in;
      e_ok_ff <= e_ok_in;
      acc_ff  <= acc_in;
      ds_ff   <= ds_in;
      lsum_ff <= lsum_in;
      if (state_ff == vwc_pkg::S_CMP && tab_ff) l_ok_ff <= win_ok;
      if (start && !busy) begin
         ev_ff <= req_electron_vertex;
         d_ff  <= 17'(req_electron_vertex) - 17'(req_lead_vertex);
         ea_ff <= req_electron_angle;
         la_ff <= req_lead_angle;
         kind_load_ff <= ld_go;
         if (kind == vwc_pkg::KIND_LOAD_E)
            stat_ff <= (e_cnt_ff == FULL) ? vwc_pkg::ST_DROPPED : vwc_pkg::ST_STORED;
         else if (kind == vwc_pkg::KIND_LOAD_L)
            stat_ff <= (l_cnt_ff == FULL) ? vwc_pkg::ST_DROPPED : vwc_pkg::ST_STORED;
         else
            stat_ff <= vwc_pkg::ST_EVALUATED;
      end
   end

   // result outputs
   logic t_ok, ew, lw;
   always_comb begin
      busy = (state_ff != vwc_pkg::S_IDLE);
      t_ok = (ev_ff >= vz_min_ff) && (ev_ff <= vz_max_ff);
      if (fixed_ff) begin
         ew = (d_ff >= -17'(signed'({1'b0, half_ff})))
              && (d_ff <= 17'(signed'({1'b0, half_ff})));
         lw = 1'b1;
      end else begin
         ew = e_ok_ff;
         lw = l_ok_ff;
      end
      rsp_status             = stat_ff;
      rsp_target_ok          = !kind_load_ff && t_ok;
      rsp_electron_window_ok = !kind_load_ff && ew;
      rsp_lead_window_ok     = !kind_load_ff && lw;
      rsp_accepted           = !kind_load_ff && t_ok && ew && lw;
   end

`ifndef NO_ASSERTIONS
   a_no_start_busy: assert property (@(posedge clock) disable iff (reset)
      busy |-> !rsp_valid || state_ff == vwc_pkg::S_IDLE)
      else $error("result while busy");
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      e_cnt_ff <= FULL && l_cnt_ff <= FULL)
      else $error("knot count overflow");
   a_done_valid: assert property (@(posedge clock) disable iff (reset)
      state_ff == vwc_pkg::S_DONE |=> rsp_valid)
      else $error("missing result strobe");
`endif
endmodule
`default_nettype wire
